/* rtl/cdte_pkg.sv */
package cdte_pkg;

    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned SECS_W   = 32;

    // day count since the epoch, valid dates only
    localparam int unsigned DAYS_W   = 20;
    // seconds within one day, wide enough for any unchecked field pattern
    localparam int unsigned TOD_W    = 17;
    localparam int unsigned DOY_W    = 9;

    localparam logic [YEAR_W-1:0]   EPOCH_YEAR       = 12'd1970;
    localparam logic [16:0]         SECS_PER_DAY     = 17'd86400;
    localparam logic [11:0]         SECS_PER_HOUR    = 12'd3600;
    localparam logic [5:0]          SECS_PER_MINUTE  = 6'd60;
    localparam logic [8:0]          DAYS_COMMON_YEAR = 9'd365;
    // leap years in 1..1969
    localparam logic [10:0]         LEAPS_BEFORE_EPOCH = 11'd477;

    localparam logic [MONTH_W-1:0]  MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_DEC = 4'd12;

    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
    localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;

    // floor(y/100) for y below 4096 as (y * 1311) >> 17
    localparam logic [10:0]         DIV100_MUL   = 11'd1311;
    localparam int unsigned         DIV100_SHIFT = 17;
    localparam logic [6:0]          HUNDRED      = 7'd100;

    typedef logic [YEAR_W-1:0] year_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [DOY_W-1:0] days_ahead(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* rtl/civil_date_to_epoch_seconds.sv */
// channel | ports                                        | direction
// --------+----------------------------------------------+----------
// input   | s_valid s_ready s_year s_month s_day s_hour  | in
//         | s_minute s_second                            |
// result  | m_valid m_ready m_epoch_seconds m_rejected   | out
//
// four register stages: range checks and year/100 estimate, leap and
// calendar terms, day count, day*86400 multiply and final sum
// one transaction per cycle sustained while m_ready is held high
// each stage loads when it is empty or the next one moves, so bubbles collapse
// and a stall on m_ready backs up without loss
// aresetn clears the valid bits only
module civil_date_to_epoch_seconds (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cdte_pkg::YEAR_W-1:0]   s_year,
    input  logic [cdte_pkg::MONTH_W-1:0]  s_month,
    input  logic [cdte_pkg::DAY_W-1:0]    s_day,
    input  logic [cdte_pkg::HOUR_W-1:0]   s_hour,
    input  logic [cdte_pkg::MINUTE_W-1:0] s_minute,
    input  logic [cdte_pkg::SECOND_W-1:0] s_second,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cdte_pkg::SECS_W-1:0]   m_epoch_seconds,
    output logic                          m_rejected
);

    // stage valid bits and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    // stage 1
    cdte_pkg::year_t                 year1_reg;
    logic [cdte_pkg::MONTH_W-1:0]    month1_reg;
    logic [cdte_pkg::DAY_W-1:0]      day1_reg;
    logic [cdte_pkg::HOUR_W-1:0]     hour1_reg;
    logic [cdte_pkg::MINUTE_W-1:0]   minute1_reg;
    logic [cdte_pkg::SECOND_W-1:0]   second1_reg;
    logic [5:0]                      q1_reg, q1_next;
    logic                            bad1_reg, bad1_next;
    logic [22:0]                     div_prod;

    always_comb begin
        div_prod = 23'(s_year) * 23'(cdte_pkg::DIV100_MUL);
        q1_next  = div_prod[cdte_pkg::DIV100_SHIFT +: 6];
        bad1_next = (s_year < cdte_pkg::EPOCH_YEAR) ||
                    (s_month < cdte_pkg::MONTH_JAN) ||
                    (s_month > cdte_pkg::MONTH_DEC) ||
                    (s_day == '0) ||
                    (s_hour > cdte_pkg::HOUR_MAX) ||
                    (s_minute > cdte_pkg::MINUTE_MAX) ||
                    (s_second > cdte_pkg::SECOND_MAX);
    end

    // stage 2
    logic                            bad2_reg, bad2_next;
    logic [cdte_pkg::YEAR_W-1:0]     yl2_reg, yl2_next;
    logic [10:0]                     ly2_reg, ly2_next;
    logic [cdte_pkg::DOY_W-1:0]      doy2_reg, doy2_next;
    logic [cdte_pkg::DAY_W-1:0]      day2_reg;
    logic [cdte_pkg::TOD_W-1:0]      tod2_reg, tod2_next;
    logic [cdte_pkg::YEAR_W-1:0]     rem_est, rem_fix;
    logic [5:0]                      q_fix;
    logic                            rem_over, leap;
    logic [cdte_pkg::DAY_W:0]        max_day;
    logic [10:0]                     leaps_thru;

    always_comb begin
        rem_est  = year1_reg - 12'(q1_reg) * 12'(cdte_pkg::HUNDRED);
        rem_over = rem_est >= 12'(cdte_pkg::HUNDRED);
        rem_fix  = rem_over ? rem_est - 12'(cdte_pkg::HUNDRED) : rem_est;
        q_fix    = q1_reg + 6'(rem_over);
        // divisible by 4 and not by 100, or by 400
        leap = ((year1_reg[1:0] == 2'b00) && (rem_fix != '0)) ||
               ((rem_fix == '0) && (q_fix[1:0] == 2'b00));
        max_day = {1'b0, cdte_pkg::month_len(month1_reg)} +
                  6'((month1_reg == cdte_pkg::MONTH_FEB) && leap);
        bad2_next = bad1_reg || ({1'b0, day1_reg} > max_day);
        // leaps in 1..year, then drop this year and those before the epoch
        leaps_thru = {1'b0, year1_reg[11:2]} - {5'b0, q_fix} + {7'b0, q_fix[5:2]};
        ly2_next   = leaps_thru - 11'(leap) - cdte_pkg::LEAPS_BEFORE_EPOCH;
        yl2_next   = year1_reg - cdte_pkg::EPOCH_YEAR;
        doy2_next  = cdte_pkg::days_ahead(month1_reg) +
                     9'((month1_reg > cdte_pkg::MONTH_FEB) && leap);
        tod2_next  = 17'(hour1_reg) * 17'(cdte_pkg::SECS_PER_HOUR) +
                     17'(minute1_reg) * 17'(cdte_pkg::SECS_PER_MINUTE) +
                     17'(second1_reg);
    end

    // stage 3
    logic                            bad3_reg;
    logic [cdte_pkg::DAYS_W-1:0]     days3_reg, days3_next;
    logic [cdte_pkg::TOD_W-1:0]      tod3_reg;

    always_comb begin
        days3_next = 20'(yl2_reg) * 20'(cdte_pkg::DAYS_COMMON_YEAR) + 20'(ly2_reg) +
                     20'(doy2_reg) + 20'(day2_reg) - 20'd1;
    end

    // stage 4, output register
    logic [cdte_pkg::SECS_W-1:0]     secs4_reg, secs4_next;
    logic                            bad4_reg;

    always_comb begin
        secs4_next = bad3_reg ? '0 :
                     32'(days3_reg) * 32'(cdte_pkg::SECS_PER_DAY) + 32'(tod3_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            year1_reg   <= s_year;
            month1_reg  <= s_month;
            day1_reg    <= s_day;
            hour1_reg   <= s_hour;
            minute1_reg <= s_minute;
            second1_reg <= s_second;
            q1_reg      <= q1_next;
            bad1_reg    <= bad1_next;
        end
        if (rdy2) begin
            bad2_reg <= bad2_next;
            yl2_reg  <= yl2_next;
            ly2_reg  <= ly2_next;
            doy2_reg <= doy2_next;
            day2_reg <= day1_reg;
            tod2_reg <= tod2_next;
        end
        if (rdy3) begin
            bad3_reg  <= bad2_reg;
            days3_reg <= days3_next;
            tod3_reg  <= tod2_reg;
        end
        if (rdy4) begin
            secs4_reg <= secs4_next;
            bad4_reg  <= bad3_reg;
        end
    end

    assign m_valid         = v4_reg;
    assign m_epoch_seconds = secs4_reg;
    assign m_rejected      = bad4_reg;

endmodule
